>>> hw/rtl/rau_pkg.sv
// Shared types and constants for the rational approximation unit.
package rau_pkg;

  localparam int FRAC_BITS_DEF = 32;
  localparam int MAX_TERMS_DEF = 48;

  localparam int VAL_W  = 63;
  localparam int NUM_W  = 31;
  localparam int WORD_W = 32;
  localparam int PROD_W = 64;

  localparam logic [NUM_W-1:0]  MAXD_RESET = 31'h0000_FFFF;
  localparam logic [NUM_W-1:0]  NUM_LIMIT  = 31'h7FFF_FFFF;
  localparam logic [WORD_W-1:0] NUM_CAP    = 32'h8000_0000;

  typedef enum logic [2:0] {
    S_IDLE,
    S_MUL_Q,
    S_CMP_Q,
    S_UPDATE,
    S_DIV_WAIT,
    S_DIV_CHECK,
    S_FINISH
  } state_t;

  typedef struct packed {
    logic load;
    logic mul_q;
    logic mul_p;
    logic save_q;
    logic update;
    logic div_start;
    logic advance;
    logic finish;
  } rau_cmd_t;

  typedef struct packed {
    logic q_over;
    logic rem_zero;
    logic div_done;
    logic quo_bad;
  } rau_status_t;

endpackage

>>> hw/rtl/rau_div.sv
// Radix-2 restoring divider, one quotient bit per cycle.
module rau_div #(
  parameter int FRAC_BITS = rau_pkg::FRAC_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  input  logic [FRAC_BITS:0]   dividend,
  input  logic [FRAC_BITS-1:0] divisor,
  output logic                 done,
  output logic [FRAC_BITS:0]   quo,
  output logic [FRAC_BITS-1:0] rem
);

  localparam int CNT_W = $clog2(FRAC_BITS + 2);

  logic                 busy;
  logic [CNT_W-1:0]     cnt;
  logic [FRAC_BITS:0]   shreg;
  logic [FRAC_BITS-1:0] part;
  logic [FRAC_BITS:0]   trial;
  logic [FRAC_BITS:0]   diff;
  logic                 ge;

  assign trial = {part, shreg[FRAC_BITS]};
  assign ge    = trial >= (FRAC_BITS+1)'(divisor);
  assign diff  = trial - (FRAC_BITS+1)'(divisor);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CNT_W'(FRAC_BITS + 1);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      shreg <= dividend;
      part  <= '0;
    end else if (busy) begin
      shreg <= {shreg[FRAC_BITS-1:0], ge};
      part  <= ge ? diff[FRAC_BITS-1:0] : trial[FRAC_BITS-1:0];
    end
  end

  assign quo = shreg;
  assign rem = part;

  a_last_step_done: assert property (@(posedge clk) disable iff (rst)
    busy && !start && cnt == CNT_W'(1) |=> done && !busy)
    else $error("divider missed its final step");

endmodule

>>> hw/rtl/rau_ctrl.sv
// Sequencer for the continued fraction expansion.
module rau_ctrl #(
  parameter int MAX_TERMS = rau_pkg::MAX_TERMS_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  output logic                 busy,
  output rau_pkg::rau_cmd_t    cmd,
  input  rau_pkg::rau_status_t status
);

  localparam int ITER_W = $clog2(MAX_TERMS + 1);

  rau_pkg::state_t state, state_next;
  logic [ITER_W-1:0] iter, iter_next;
  logic [ITER_W-1:0] iter_inc;

  assign iter_inc = iter + 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= rau_pkg::S_IDLE;
      iter  <= '0;
    end else begin
      state <= state_next;
      iter  <= iter_next;
    end
  end

  always_comb begin
    state_next = state;
    iter_next  = iter;
    cmd        = '0;
    busy       = 1'b1;
    unique case (state)
      rau_pkg::S_IDLE: begin
        busy = 1'b0;
        if (start) begin
          cmd.load   = 1'b1;
          iter_next  = '0;
          state_next = rau_pkg::S_MUL_Q;
        end
      end
      rau_pkg::S_MUL_Q: begin
        cmd.mul_q  = 1'b1;
        state_next = rau_pkg::S_CMP_Q;
      end
      rau_pkg::S_CMP_Q: begin
        if (status.q_over) begin
          state_next = rau_pkg::S_FINISH;
        end else begin
          cmd.mul_p  = 1'b1;
          cmd.save_q = 1'b1;
          state_next = rau_pkg::S_UPDATE;
        end
      end
      rau_pkg::S_UPDATE: begin
        cmd.update = 1'b1;
        if (status.rem_zero) begin
          state_next = rau_pkg::S_FINISH;
        end else begin
          cmd.div_start = 1'b1;
          state_next    = rau_pkg::S_DIV_WAIT;
        end
      end
      rau_pkg::S_DIV_WAIT: begin
        if (status.div_done) begin
          state_next = rau_pkg::S_DIV_CHECK;
        end
      end
      rau_pkg::S_DIV_CHECK: begin
        if (status.quo_bad) begin
          state_next = rau_pkg::S_FINISH;
        end else begin
          cmd.advance = 1'b1;
          iter_next   = iter_inc;
          state_next  = (iter_inc == ITER_W'(MAX_TERMS)) ? rau_pkg::S_FINISH
                                                          : rau_pkg::S_MUL_Q;
        end
      end
      rau_pkg::S_FINISH: begin
        cmd.finish = 1'b1;
        state_next = rau_pkg::S_IDLE;
      end
      default: begin
        state_next = rau_pkg::S_IDLE;
      end
    endcase
  end

  a_start_enters_loop: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> state == rau_pkg::S_MUL_Q)
    else $error("accepted item did not start the expansion");

  a_term_bound: assert property (@(posedge clk) disable iff (rst)
    iter <= ITER_W'(MAX_TERMS))
    else $error("term count past its limit");

endmodule

>>> hw/rtl/rau_dp.sv
// Datapath: convergent registers, shared multiplier, divider and result registers.
module rau_dp #(
  parameter int FRAC_BITS = rau_pkg::FRAC_BITS_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  rau_pkg::rau_cmd_t           cmd,
  output rau_pkg::rau_status_t        status,
  input  logic [rau_pkg::VAL_W-1:0]   value_fixed,
  input  logic [rau_pkg::NUM_W-1:0]   max_den,
  output logic                        done,
  output logic [rau_pkg::NUM_W-1:0]   numerator,
  output logic [rau_pkg::NUM_W-1:0]   denominator,
  output logic                        overflow
);

  logic [rau_pkg::WORD_W-1:0] a;
  logic [FRAC_BITS:0]         d;
  logic [FRAC_BITS-1:0]       r;
  logic [rau_pkg::WORD_W-1:0] p_cur, p_prev;
  logic [rau_pkg::NUM_W-1:0]  q_cur, q_prev, q_new;
  logic [rau_pkg::PROD_W-1:0] prod;
  logic [rau_pkg::WORD_W-1:0] ip_sat;
  logic                       accepted;

  logic [rau_pkg::PROD_W-1:0] ip_ext;
  logic [rau_pkg::WORD_W-1:0] ip_cap;
  logic [rau_pkg::WORD_W-1:0] mul_b;
  logic [rau_pkg::PROD_W-1:0] qsum;
  logic [rau_pkg::PROD_W-1:0] psum;
  logic [rau_pkg::WORD_W-1:0] p_new;
  logic [rau_pkg::WORD_W-1:0] res_num;

  logic                 div_done;
  logic [FRAC_BITS:0]   div_quo;
  logic [FRAC_BITS-1:0] div_rem;

  rau_div #(.FRAC_BITS(FRAC_BITS)) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.div_start),
    .dividend (d),
    .divisor  (r),
    .done     (div_done),
    .quo      (div_quo),
    .rem      (div_rem)
  );

  assign ip_ext = rau_pkg::PROD_W'(value_fixed >> FRAC_BITS);
  assign ip_cap = (ip_ext > rau_pkg::PROD_W'(rau_pkg::NUM_CAP)) ? rau_pkg::NUM_CAP
                                                                 : ip_ext[rau_pkg::WORD_W-1:0];

  assign mul_b = cmd.mul_p ? p_cur : rau_pkg::WORD_W'(q_cur);
  assign qsum  = prod + rau_pkg::PROD_W'(q_prev);
  assign psum  = prod + rau_pkg::PROD_W'(p_prev);
  assign p_new = (psum > rau_pkg::PROD_W'(rau_pkg::NUM_CAP)) ? rau_pkg::NUM_CAP
                                                              : psum[rau_pkg::WORD_W-1:0];

  assign res_num = accepted ? p_cur : ip_sat;

  // q_prev never exceeds q_prev + a*q_cur, so one compare covers both limits
  assign status.q_over   = qsum > rau_pkg::PROD_W'(max_den);
  assign status.rem_zero = (r == '0);
  assign status.div_done = div_done;
  assign status.quo_bad  =
    (rau_pkg::PROD_W'(div_quo) > rau_pkg::PROD_W'(rau_pkg::NUM_LIMIT)) ||
    ((rau_pkg::PROD_W'(div_quo) == rau_pkg::PROD_W'(rau_pkg::NUM_LIMIT)) &&
     (div_rem != '0));

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      a        <= ip_cap;
      ip_sat   <= ip_cap;
      d        <= {1'b1, {FRAC_BITS{1'b0}}};
      r        <= value_fixed[FRAC_BITS-1:0];
      p_cur    <= rau_pkg::WORD_W'(1);
      p_prev   <= '0;
      q_cur    <= '0;
      q_prev   <= rau_pkg::NUM_W'(1);
      accepted <= 1'b0;
    end
    if (cmd.mul_q || cmd.mul_p) begin
      prod <= rau_pkg::PROD_W'(a) * rau_pkg::PROD_W'(mul_b);
    end
    if (cmd.save_q) begin
      q_new <= qsum[rau_pkg::NUM_W-1:0];
    end
    if (cmd.update) begin
      p_prev <= p_cur;
      p_cur  <= p_new;
      q_prev <= q_cur;
      q_cur  <= q_new;
    end
    if (cmd.advance) begin
      a        <= rau_pkg::WORD_W'(div_quo);
      d        <= (FRAC_BITS+1)'(r);
      r        <= div_rem;
      accepted <= 1'b1;
    end
    if (cmd.finish) begin
      if (res_num > rau_pkg::WORD_W'(rau_pkg::NUM_LIMIT)) begin
        numerator <= rau_pkg::NUM_LIMIT;
        overflow  <= 1'b1;
      end else begin
        numerator <= res_num[rau_pkg::NUM_W-1:0];
        overflow  <= 1'b0;
      end
      denominator <= accepted ? q_cur : rau_pkg::NUM_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= cmd.finish;
    end
  end

  a_single_strobe: assert property (@(posedge clk) disable iff (rst)
    done |=> !done)
    else $error("result strobe held for two cycles");

  a_den_nonzero: assert property (@(posedge clk) disable iff (rst)
    done |-> denominator != '0)
    else $error("zero denominator delivered");

endmodule

>>> hw/rtl/rational_approximation_unit_core.sv
// Top level of the continued fraction rational approximation unit.
// The serial divider, one quotient bit per cycle, sets the per-term cost.
// Throughput: one item at a time; busy stays high until the result is latched.
// Result shows for one cycle on done and cannot be stalled by the receiver.
// Synchronous reset returns to idle and sets max_denominator to 65535.
module rational_approximation_unit_core #(
  parameter int FRAC_BITS = rau_pkg::FRAC_BITS_DEF,
  parameter int MAX_TERMS = rau_pkg::MAX_TERMS_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  output logic                       busy,
  input  logic [rau_pkg::VAL_W-1:0]  value_fixed,
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic [rau_pkg::NUM_W-1:0]  cfg_data,
  output logic                       done,
  output logic [rau_pkg::NUM_W-1:0]  numerator,
  output logic [rau_pkg::NUM_W-1:0]  denominator,
  output logic                       overflow
);

  rau_pkg::rau_cmd_t    cmd;
  rau_pkg::rau_status_t status;
  logic [rau_pkg::NUM_W-1:0] max_denominator;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_denominator <= rau_pkg::MAXD_RESET;
    end else if (cfg_valid && cfg_ready) begin
      max_denominator <= cfg_data;
    end
  end

  rau_ctrl #(.MAX_TERMS(MAX_TERMS)) u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .busy   (busy),
    .cmd    (cmd),
    .status (status)
  );

  rau_dp #(.FRAC_BITS(FRAC_BITS)) u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .status      (status),
    .value_fixed (value_fixed),
    .max_den     (max_denominator),
    .done        (done),
    .numerator   (numerator),
    .denominator (denominator),
    .overflow    (overflow)
  );

endmodule

>>> test/rational_approximation_unit_core_tb.sv
// Self-checking testbench for the continued fraction rational approximation unit.
`timescale 1ns / 100ps

module rational_approximation_unit_core_tb;
  import rau_pkg::*;

  localparam int          FRAC_BITS   = FRAC_BITS_DEF;
  localparam int          MAX_TERMS   = MAX_TERMS_DEF;
  localparam int unsigned CYCLE_LIMIT = 2_000_000;
  localparam int unsigned DRAIN_WAIT  = 2000;
  localparam logic [63:0] CAP64       = {32'd0, NUM_CAP};
  localparam logic [63:0] LIMIT64     = {33'd0, NUM_LIMIT};

  typedef struct {
    logic [NUM_W-1:0] num;
    logic [NUM_W-1:0] den;
    logic             ovf;
  } approx_t;

  logic               clk;
  logic               rst         = 1'b1;
  logic               start       = 1'b0;
  logic [VAL_W-1:0]   value_fixed = '0;
  logic               cfg_valid   = 1'b0;
  logic [NUM_W-1:0]   cfg_data    = '0;
  logic               busy;
  logic               cfg_ready;
  logic               done;
  logic [NUM_W-1:0]   numerator;
  logic [NUM_W-1:0]   denominator;
  logic               overflow;

  approx_t            pending_results[$];
  approx_t            want;
  logic [NUM_W-1:0]   max_den_setting = MAXD_RESET;
  bit                 gaps_on         = 1'b1;
  int unsigned        cycle_count     = 0;
  int unsigned        items_sent      = 0;
  int unsigned        results_seen    = 0;
  int unsigned        saturated_seen  = 0;
  int unsigned        unit_den_seen   = 0;
  int unsigned        cfg_writes      = 0;
  int unsigned        errors          = 0;

  rational_approximation_unit_core u_top (
    .clk         (clk),
    .rst         (rst),
    .start       (start),
    .busy        (busy),
    .value_fixed (value_fixed),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_data    (cfg_data),
    .done        (done),
    .numerator   (numerator),
    .denominator (denominator),
    .overflow    (overflow)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Last convergent of the continued fraction whose denominator fits the limit.
  function automatic approx_t best_fraction(input logic [VAL_W-1:0] value,
                                            input logic [NUM_W-1:0] limit);
    logic [63:0] num, den, maxd, a, t, rem, quo;
    logic [63:0] p_cur, p_prev, q_cur, q_prev, res_num, res_den;
    int          i;
    int unsigned accepted;
    approx_t     r;
    num      = {1'b0, value};
    den      = 64'd1 << FRAC_BITS;
    maxd     = {33'd0, limit};
    p_cur    = 64'd1;
    p_prev   = 64'd0;
    q_cur    = 64'd0;
    q_prev   = 64'd1;
    accepted = 0;
    for (i = 0; i < MAX_TERMS; i++) begin
      a = num / den;
      if (q_prev > maxd) break;
      if (q_cur != 0 && a > (maxd - q_prev) / q_cur) break;
      if (p_cur != 0 && a > CAP64 / p_cur) begin
        t = CAP64;
      end else begin
        t = p_cur * a + p_prev;
        if (t > CAP64) t = CAP64;
      end
      p_prev = p_cur;
      p_cur  = t;
      t      = q_cur * a + q_prev;
      q_prev = q_cur;
      q_cur  = t;
      rem    = num - a * den;
      if (rem == 0) break;
      quo = den / rem;
      if (quo > LIMIT64 || (quo == LIMIT64 && den % rem != 0)) break;
      num = den;
      den = rem;
      accepted++;
    end
    if (accepted == 0) begin
      res_num = {1'b0, value} >> FRAC_BITS;
      if (res_num > CAP64) res_num = CAP64;
      res_den = 64'd1;
    end else begin
      res_num = p_cur;
      res_den = q_cur;
    end
    if (res_num > LIMIT64) begin
      r.num = NUM_LIMIT;
      r.ovf = 1'b1;
    end else begin
      r.num = res_num[NUM_W-1:0];
      r.ovf = 1'b0;
    end
    r.den = res_den[NUM_W-1:0];
    return r;
  endfunction

  function automatic logic [VAL_W-1:0] corner_value(input int k);
    case (k)
      0:       return 63'h0;
      1:       return 63'h1;
      2:       return 63'h2;
      3:       return 63'h3;
      4:       return 63'h1_0000_0000;
      5:       return 63'h3_243F_6A88;
      6:       return 63'h2_B7E1_5162;
      7:       return 63'h1_6A09_E667;
      8:       return 63'h1_9E37_79B9;
      9:       return 63'h0_8000_0000;
      10:      return 63'h0_FFFF_FFFF;
      11:      return 63'h0_5555_5555;
      12:      return 63'h7FFF_FFFF_0000_0000;
      13:      return 63'h7FFF_FFFF_8000_0000;
      default: return 63'h7FFF_FFFF_FFFF_FFFF;
    endcase
  endfunction

  // Mix of full-width values, small integer parts, near-rationals and shifted words.
  function automatic logic [VAL_W-1:0] rand_value();
    logic [63:0] w;
    int unsigned d, n;
    w = {$urandom, $urandom};
    case ($urandom_range(0, 3))
      0: return w[VAL_W-1:0];
      1: return {27'd0, w[35:0]};
      2: begin
        d = $urandom_range(2, 5000);
        n = $urandom_range(0, 4 * d);
        w = (64'(n) << FRAC_BITS) / d + $urandom_range(0, 2);
        return w[VAL_W-1:0];
      end
      default: return w[VAL_W-1:0] >> $urandom_range(0, 62);
    endcase
  endfunction

  task automatic report_mismatch(input string what, input longint unsigned got,
                                 input longint unsigned exp_val);
    errors++;
    $display("ERROR result %0d %s: got 0x%0h, expected 0x%0h",
             results_seen, what, got, exp_val);
  endtask

  task automatic send_value(input logic [VAL_W-1:0] v);
    if (gaps_on && $urandom_range(0, 2) == 0) begin
      start <= 1'b0;
      if ($urandom_range(0, 1) == 1) begin
        do @(posedge clk); while (busy);
      end
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
    start       <= 1'b1;
    value_fixed <= v;
    do @(posedge clk); while (busy);
    pending_results.push_back(best_fraction(v, max_den_setting));
    items_sent++;
  endtask

  task automatic wait_all_results();
    start <= 1'b0;
    do @(posedge clk); while (pending_results.size() != 0 || busy);
  endtask

  task automatic set_max_denominator(input logic [NUM_W-1:0] v);
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    max_den_setting = v;
    cfg_writes++;
  endtask

  task automatic test_reset_default();
    for (int k = 0; k < 14; k++) send_value(corner_value(k));
  endtask

  task automatic test_zero_limit();
    wait_all_results();
    set_max_denominator('0);
    send_value(corner_value(5));
    send_value(corner_value(14));
    send_value(corner_value(9));
  endtask

  task automatic test_unit_limit();
    wait_all_results();
    set_max_denominator(31'd1);
    send_value(corner_value(6));
    send_value(corner_value(10));
    send_value(corner_value(13));
  endtask

  task automatic test_full_limit();
    wait_all_results();
    set_max_denominator(NUM_LIMIT);
    for (int k = 0; k < 15; k += 2) send_value(corner_value(k));
    send_value(corner_value(13));
  endtask

  task automatic test_drain_pause();
    wait_all_results();
    set_max_denominator(NUM_W'($urandom_range(2, 100_000)));
    for (int k = 0; k < 8; k++) begin
      send_value(rand_value());
      wait_all_results();
    end
  endtask

  task automatic test_random_mix();
    logic [NUM_W-1:0] setting;
    for (int ph = 0; ph < 5; ph++) begin
      case (ph)
        0:       setting = NUM_LIMIT;
        1:       setting = NUM_W'($urandom_range(32'h0010_0000, 32'h7FFF_FFFF));
        2:       setting = NUM_W'($urandom_range(2, 1000));
        3:       setting = MAXD_RESET;
        default: setting = NUM_W'($urandom_range(0, 32'h7FFF_FFFF));
      endcase
      wait_all_results();
      set_max_denominator(setting);
      gaps_on = (ph != 4);
      for (int k = 0; k < 34; k++) send_value(rand_value());
    end
  endtask

  always @(negedge clk) begin
    if (!rst && done) begin
      if (pending_results.size() == 0) begin
        report_mismatch("unexpected result", numerator, 0);
      end else begin
        want = pending_results.pop_front();
        results_seen++;
        if (overflow) saturated_seen++;
        if (denominator == 1) unit_den_seen++;
        if (numerator !== want.num) report_mismatch("numerator", numerator, want.num);
        if (denominator !== want.den) report_mismatch("denominator", denominator, want.den);
        if (overflow !== want.ovf) report_mismatch("overflow", overflow, want.ovf);
      end
    end
  end

  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("timeout after %0d cycles", cycle_count);
    $display("rational_approximation_unit_core regression: fail");
    $finish;
  end

  initial begin
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    test_reset_default();
    test_zero_limit();
    test_unit_limit();
    test_full_limit();
    test_drain_pause();
    test_random_mix();
    wait_all_results();
    repeat (DRAIN_WAIT) @(posedge clk);
    $display("covered %0d items and %0d results across %0d max_denominator writes",
             items_sent, results_seen, cfg_writes);
    $display("saw %0d saturated numerators and %0d whole-number results, %0d errors",
             saturated_seen, unit_den_seen, errors);
    if (errors == 0) begin
      $display("rational_approximation_unit_core regression: pass");
    end else begin
      $display("rational_approximation_unit_core regression: fail");
    end
    $finish;
  end

endmodule

>>> sim.f
hw/rtl/rau_pkg.sv
hw/rtl/rau_div.sv
hw/rtl/rau_ctrl.sv
hw/rtl/rau_dp.sv
hw/rtl/rational_approximation_unit_core.sv
test/rational_approximation_unit_core_tb.sv
